// File: hdl/pto_pkg.sv
// Shared types and constants of the projective tag overlay.
package pto_pkg;

  localparam int unsigned COEF_BITS = 32;
  localparam int unsigned Q_BITS = 5;     // quotient bits kept; cells 0..31
  localparam int unsigned CFG_IDX_BITS = 4;
  localparam int unsigned CFG_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_A       = 4'd0,
    REG_COEF_B       = 4'd1,
    REG_COEF_C       = 4'd2,
    REG_COEF_D       = 4'd3,
    REG_COEF_E       = 4'd4,
    REG_TAG_CODE     = 4'd5,
    REG_GRID_SIZE    = 4'd6,
    REG_BORDER_WIDTH = 4'd7
  } pto_reg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] h00;
    logic signed [COEF_BITS-1:0] h01;
    logic signed [COEF_BITS-1:0] h02;
    logic signed [COEF_BITS-1:0] h10;
    logic signed [COEF_BITS-1:0] h11;
    logic signed [COEF_BITS-1:0] h12;
    logic signed [COEF_BITS-1:0] h20;
    logic signed [COEF_BITS-1:0] h21;
    logic signed [COEF_BITS-1:0] h22;
    logic [63:0]                 code;
    logic [3:0]                  grid_size;
    logic [1:0]                  border_width;
  } pto_cfg_t;

  // Control carried with each request through the divider
  typedef struct packed {
    logic              miss;   // zero denominator, negative or too large quotient
    logic [Q_BITS-1:0] qx;
    logic [Q_BITS-1:0] qy;
    logic [7:0]        old;
  } pto_ctl_t;

endpackage

// File: hdl/pto_if.sv
// Channel interfaces: pixel input, pixel output and register write.
interface pto_pix_in_if #(parameter int unsigned COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [7:0]            old_pixel;
  modport source (output valid, pixel_x, pixel_y, old_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, old_pixel, output ready);
endinterface

interface pto_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] new_pixel;
  logic       covered;
  modport source (output valid, new_pixel, covered, input ready);
  modport sink (input valid, new_pixel, covered, output ready);
endinterface

interface pto_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/pto_cfg_regs.sv
// Configuration register file.
module pto_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr,
  input  logic [3:0]                  index,
  input  logic [63:0]                 data,
  output pto_pkg::pto_cfg_t           cfg
);
  import pto_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{grid_size: 4'd6, border_width: 2'd1, default: '0};
    end else if (wr) begin
      case (pto_reg_t'(index))
        REG_COEF_A: begin
          cfg.h00 <= data[63:32];
          cfg.h01 <= data[31:0];
        end
        REG_COEF_B: begin
          cfg.h02 <= data[63:32];
          cfg.h10 <= data[31:0];
        end
        REG_COEF_C: begin
          cfg.h11 <= data[63:32];
          cfg.h12 <= data[31:0];
        end
        REG_COEF_D: begin
          cfg.h20 <= data[63:32];
          cfg.h21 <= data[31:0];
        end
        REG_COEF_E:       cfg.h22 <= data[31:0];
        REG_TAG_CODE:     cfg.code <= data;
        REG_GRID_SIZE:    cfg.grid_size <= data[3:0];
        REG_BORDER_WIDTH: cfg.border_width <= data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/pto_front.sv
// Front end: products, projective sums, sign normalisation for the divider.
module pto_front #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned UW = 60
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [7:0]            old_pixel,
  input  pto_pkg::pto_cfg_t     cfg,
  output pto_pkg::pto_ctl_t     ctl,
  output logic [UW-1:0]         rx,
  output logic [UW-1:0]         ry,
  output logic [UW-1:0]         d
);
  import pto_pkg::*;

  localparam int unsigned PW  = COORD_BITS + 2;
  localparam int unsigned PRW = COEF_BITS + PW;
  localparam int unsigned SW  = PRW + 2;
  localparam int unsigned NW  = SW + 2;

  logic signed [PW-1:0]  px2, py2;
  logic signed [PRW-1:0] p00, p01, p10, p11, p20, p21;
  logic [7:0]            old1, old2;
  logic signed [SW-1:0]  nx, ny, w;
  logic signed [NW-1:0]  ax, ay, wv, sx, sy, dd;
  logic                  sgn;

  assign px2 = $signed({1'b0, pixel_x, 1'b1});
  assign py2 = $signed({1'b0, pixel_y, 1'b1});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p00  <= PRW'(cfg.h00) * PRW'(px2);
      p01  <= PRW'(cfg.h01) * PRW'(py2);
      p10  <= PRW'(cfg.h10) * PRW'(px2);
      p11  <= PRW'(cfg.h11) * PRW'(py2);
      p20  <= PRW'(cfg.h20) * PRW'(px2);
      p21  <= PRW'(cfg.h21) * PRW'(py2);
      old1 <= old_pixel;
    end
    if (en[1]) begin
      nx   <= SW'(p00) + SW'(p01) + (SW'(cfg.h02) <<< 1);
      ny   <= SW'(p10) + SW'(p11) + (SW'(cfg.h12) <<< 1);
      w    <= SW'(p20) + SW'(p21) + (SW'(cfg.h22) <<< 1);
      old2 <= old1;
    end
  end

  // 2n + w over 2w with the divisor made positive
  always_comb begin
    sgn = w[SW-1];
    wv  = NW'(w);
    ax  = NW'(nx) <<< 1;
    ay  = NW'(ny) <<< 1;
    sx  = sgn ? (-ax - wv) : (ax + wv);
    sy  = sgn ? (-ay - wv) : (ay + wv);
    dd  = sgn ? -(wv <<< 1) : (wv <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ctl.miss <= (w == '0) || sx[NW-1] || sy[NW-1];
      ctl.qx   <= '0;
      ctl.qy   <= '0;
      ctl.old  <= old2;
      rx       <= UW'($unsigned(sx));
      ry       <= UW'($unsigned(sy));
      d        <= UW'($unsigned(dd));
    end
  end

endmodule

// File: hdl/pto_div_step.sv
// One restoring division step for both axes; the top step checks the range.
module pto_div_step #(
  parameter int unsigned UW = 60,
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  pto_pkg::pto_ctl_t ctl_in,
  input  logic [UW-1:0]     rx_in,
  input  logic [UW-1:0]     ry_in,
  input  logic [UW-1:0]     d_in,
  output pto_pkg::pto_ctl_t ctl,
  output logic [UW-1:0]     rx,
  output logic [UW-1:0]     ry,
  output logic [UW-1:0]     d
);
  import pto_pkg::*;

  logic [UW-1:0] trial, rx_next, ry_next;
  logic          gex, gey;
  pto_ctl_t      ctl_next;

  always_comb begin
    trial    = d_in << SHIFT;
    gex      = rx_in >= trial;
    gey      = ry_in >= trial;
    ctl_next = ctl_in;
    rx_next  = rx_in;
    ry_next  = ry_in;
    if (SHIFT == Q_BITS) begin
      // quotient of 32 or more lies outside any grid
      ctl_next.miss = ctl_in.miss | gex | gey;
    end else begin
      if (gex) rx_next = rx_in - trial;
      if (gey) ry_next = ry_in - trial;
      ctl_next.qx = ctl_in.qx | (Q_BITS'(gex) << SHIFT);
      ctl_next.qy = ctl_in.qy | (Q_BITS'(gey) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_next;
      rx  <= rx_next;
      ry  <= ry_next;
      d   <= d_in;
    end
  end

endmodule

// File: hdl/pto_cell.sv
// Tag cell lookup and output register.
module pto_cell (
  input  logic              clk,
  input  logic              en,
  input  pto_pkg::pto_ctl_t ctl,
  input  pto_pkg::pto_cfg_t cfg,
  output logic [7:0]        new_pixel,
  output logic              covered
);
  import pto_pkg::*;

  logic [5:0] side, tb, cx, cy, kx, ky;
  logic [7:0] k, pos, sq;
  logic       in_grid, rim, code_area, bit_set;

  always_comb begin
    tb        = 6'd1 + 6'(cfg.border_width);
    side      = (tb <<< 1) + 6'(cfg.grid_size);
    cx        = 6'(ctl.qx);
    cy        = 6'(ctl.qy);
    in_grid   = !ctl.miss && (cx < side) && (cy < side);
    rim       = (cx == 6'd0) || (cy == 6'd0) || (cx == side - 6'd1) || (cy == side - 6'd1);
    code_area = (cx >= tb) && (cx < tb + 6'(cfg.grid_size)) &&
                (cy >= tb) && (cy < tb + 6'(cfg.grid_size));
    kx        = cx - tb;
    ky        = cy - tb;
    sq        = 8'(cfg.grid_size) * 8'(cfg.grid_size);
    k         = 8'(ky) * 8'(cfg.grid_size) + 8'(kx);
    pos       = sq - 8'd1 - k;
    bit_set   = (pos < 8'd64) && cfg.code[pos[5:0]];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      covered <= in_grid;
      if (!in_grid) new_pixel <= ctl.old;
      else if (rim || (code_area && bit_set)) new_pixel <= 8'd255;
      else new_pixel <= 8'd0;
    end
  end

endmodule

// File: hdl/projective_tag_overlay_unit.sv
// Top level of the projective tag overlay unit.
// Throughput: one pixel per cycle; ten pipeline stages (products, sums,
// normalisation, six division steps, cell lookup), each stage stalls only
// when it is full and the one after it cannot take its request.
// Reset clears the valid bits and loads the register defaults.
module projective_tag_overlay_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  pto_pix_in_if.sink   pixel_in,
  pto_pix_out_if.source pixel_out,
  pto_cfg_if.sink      cfg_wr
);
  import pto_pkg::*;

  localparam int unsigned NW = COEF_BITS + COORD_BITS + 6;
  localparam int unsigned UW = NW + 5;
  localparam int unsigned DIV_STEPS = Q_BITS + 1;
  localparam int unsigned STAGES = DIV_STEPS + 4;

  pto_cfg_t        cfg;
  logic [STAGES-1:0] v;
  logic [STAGES:0]   en;
  pto_ctl_t        ctl_s [DIV_STEPS+1];
  logic [UW-1:0]   rx_s [DIV_STEPS+1];
  logic [UW-1:0]   ry_s [DIV_STEPS+1];
  logic [UW-1:0]   d_s [DIV_STEPS+1];

  assign cfg_wr.ready = 1'b1;

  pto_cfg_regs u_cfg (
    .clk, .rst,
    .wr(cfg_wr.valid && cfg_wr.ready),
    .index(cfg_wr.index),
    .data(cfg_wr.data),
    .cfg
  );

  always_comb begin
    en[STAGES] = pixel_out.ready;
    for (int i = STAGES - 1; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign pixel_in.ready = en[0];
  assign pixel_out.valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= pixel_in.valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  pto_front #(.COORD_BITS(COORD_BITS), .UW(UW)) u_front (
    .clk,
    .en(en[2:0]),
    .pixel_x(pixel_in.pixel_x),
    .pixel_y(pixel_in.pixel_y),
    .old_pixel(pixel_in.old_pixel),
    .cfg,
    .ctl(ctl_s[0]),
    .rx(rx_s[0]),
    .ry(ry_s[0]),
    .d(d_s[0])
  );

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    pto_div_step #(.UW(UW), .SHIFT(Q_BITS - j)) u_step (
      .clk,
      .en(en[3+j]),
      .ctl_in(ctl_s[j]),
      .rx_in(rx_s[j]),
      .ry_in(ry_s[j]),
      .d_in(d_s[j]),
      .ctl(ctl_s[j+1]),
      .rx(rx_s[j+1]),
      .ry(ry_s[j+1]),
      .d(d_s[j+1])
    );
  end

  pto_cell u_cell (
    .clk,
    .en(en[STAGES-1]),
    .ctl(ctl_s[DIV_STEPS]),
    .cfg,
    .new_pixel(pixel_out.new_pixel),
    .covered(pixel_out.covered)
  );

  a_cover_bw: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid && pixel_out.covered |->
      (pixel_out.new_pixel == 8'd255 || pixel_out.new_pixel == 8'd0))
    else $error("covered pixel not black or white");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pixel_in.valid && pixel_in.ready |=> v[0])
    else $error("accepted request lost at first stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v[STAGES-1] |-> pixel_in.ready)
    else $error("input stalled with output stage empty");

endmodule

// File: bench/tb_projective_tag_overlay_unit.sv
// Self-checking testbench of the projective tag overlay unit.
module tb_projective_tag_overlay_unit;
  import pto_pkg::*;

  localparam logic [3:0] REG_UNUSED = 4'd11;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 14;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  old;
  } pixel_req_t;

  typedef struct {
    logic [7:0] value;
    logic       covered;
  } paint_t;

  logic clk;
  logic rst;

  pto_pix_in_if #(.COORD_BITS(12)) pixel_in ();
  pto_pix_out_if pixel_out ();
  pto_cfg_if cfg_wr ();

  projective_tag_overlay_unit #(.COORD_BITS(12)) u_top (
    .clk(clk),
    .rst(rst),
    .pixel_in(pixel_in),
    .pixel_out(pixel_out),
    .cfg_wr(cfg_wr)
  );

  pixel_req_t pending_pixels[$];
  paint_t     expected_paint[$];
  pto_cfg_t   shadow;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         cycle_count;
  int         error_count;
  int         warp_span;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic paint_t paint_pixel(pixel_req_t p);
    paint_t r;
    longint px2, py2, nx, ny, w, ix, iy, d, tb, side, k, pos;
    px2 = 2 * longint'(p.x) + 1;
    py2 = 2 * longint'(p.y) + 1;
    nx = shadow.h00 * px2 + shadow.h01 * py2 + 2 * longint'(shadow.h02);
    ny = shadow.h10 * px2 + shadow.h11 * py2 + 2 * longint'(shadow.h12);
    w  = shadow.h20 * px2 + shadow.h21 * py2 + 2 * longint'(shadow.h22);
    r.value = p.old;
    r.covered = 1'b0;
    if (w == 0) return r;
    ix = floor_quot(2 * nx + w, 2 * w);
    iy = floor_quot(2 * ny + w, 2 * w);
    d = longint'(shadow.grid_size);
    tb = 1 + longint'(shadow.border_width);
    side = 2 * tb + d;
    if (ix < 0 || ix >= side || iy < 0 || iy >= side) return r;
    r.covered = 1'b1;
    if (ix == 0 || iy == 0 || ix == side - 1 || iy == side - 1) begin
      r.value = 8'd255;
    end else if (ix >= tb && ix < tb + d && iy >= tb && iy < tb + d) begin
      k = (iy - tb) * d + (ix - tb);
      pos = d * d - 1 - k;
      r.value = (pos < 64 && shadow.code[pos]) ? 8'd255 : 8'd0;
    end else begin
      r.value = 8'd0;
    end
    return r;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= value;
    do @(posedge clk); while (!cfg_wr.ready);
    case (idx)
      REG_COEF_A: {shadow.h00, shadow.h01} = value;
      REG_COEF_B: {shadow.h02, shadow.h10} = value;
      REG_COEF_C: {shadow.h11, shadow.h12} = value;
      REG_COEF_D: {shadow.h20, shadow.h21} = value;
      REG_COEF_E: shadow.h22 = value[31:0];
      REG_TAG_CODE: shadow.code = value;
      REG_GRID_SIZE: shadow.grid_size = value[3:0];
      REG_BORDER_WIDTH: shadow.border_width = value[1:0];
      default: ;
    endcase
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic queue_pixel(logic [11:0] x, logic [11:0] y, logic [7:0] old);
    pixel_req_t p;
    p.x = x;
    p.y = y;
    p.old = old;
    pending_pixels.push_back(p);
  endtask

  task automatic drain;
    while (pending_pixels.size() != 0 || expected_paint.size() != 0 || pixel_in.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Affine or mildly projective warp putting the tag near the image origin
  task automatic load_warp(bit persp);
    int unsigned cell_px;
    logic [31:0] h00, h01, h02, h10, h11, h12, h20, h21;
    cell_px = $urandom_range(1, 6);
    h00 = 32'(24'hFFFFFF / cell_px) + 32'($urandom_range(0, 4095));
    h11 = 32'(24'hFFFFFF / cell_px) - 32'($urandom_range(0, 4095));
    h01 = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    h10 = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    h02 = -32'($urandom_range(0, 3 << 24));
    h12 = -32'($urandom_range(0, 3 << 24));
    h20 = persp ? 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14)) : 32'd0;
    h21 = persp ? 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14)) : 32'd0;
    write_reg(REG_COEF_A, {h00, h01});
    write_reg(REG_COEF_B, {h02, h10});
    write_reg(REG_COEF_C, {h11, h12});
    write_reg(REG_COEF_D, {h20, h21});
    write_reg(REG_COEF_E, 64'(32'h0100_0000));
    warp_span = int'(cell_px) * 28;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85)
        queue_pixel(12'($urandom_range(0, warp_span)), 12'($urandom_range(0, warp_span)),
                    8'($urandom));
      else
        queue_pixel(12'($urandom), 12'($urandom), 8'($urandom));
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 60; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 60; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // Driver: takes one request from the pending queue whenever the slot is free
  always @(posedge clk) begin
    if (rst) begin
      pixel_in.valid <= 1'b0;
    end else begin
      if (pixel_in.valid && pixel_in.ready)
        expected_paint.push_back(paint_pixel('{pixel_in.pixel_x, pixel_in.pixel_y,
                                               pixel_in.old_pixel}));
      if (!pixel_in.valid || pixel_in.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pixel_req_t p;
          p = pending_pixels.pop_front();
          pixel_in.valid <= 1'b1;
          pixel_in.pixel_x <= p.x;
          pixel_in.pixel_y <= p.y;
          pixel_in.old_pixel <= p.old;
        end else begin
          pixel_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pixel_out.ready <= 1'b0;
    end else begin
      if (pixel_out.valid && pixel_out.ready) begin
        if (expected_paint.size() == 0) begin
          $display("%0t: unexpected result new_pixel=%0d covered=%0b", $time,
                   pixel_out.new_pixel, pixel_out.covered);
          error_count++;
        end else begin
          paint_t e;
          e = expected_paint.pop_front();
          if (pixel_out.new_pixel !== e.value) begin
            $display("%0t: new_pixel expected %0d actual %0d", $time, e.value,
                     pixel_out.new_pixel);
            error_count++;
          end
          if (pixel_out.covered !== e.covered) begin
            $display("%0t: covered expected %0b actual %0b", $time, e.covered,
                     pixel_out.covered);
            error_count++;
          end
        end
      end
      pixel_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("tb_projective_tag_overlay_unit failed");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    error_count = 0;
    warp_span = 40;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow = '0;
    shadow.grid_size = 4'd6;
    shadow.border_width = 2'd1;
    rst = 1'b1;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    pixel_in.valid = 1'b0;
    pixel_in.pixel_x = '0;
    pixel_in.pixel_y = '0;
    pixel_in.old_pixel = '0;
    pixel_out.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero denominator after reset: everything passes through
    queue_pixel(12'd0, 12'd0, 8'd0);
    queue_pixel(12'hFFF, 12'hFFF, 8'hFF);
    queue_pixel(12'hFFF, 12'd0, 8'h5A);
    queue_pixel(12'd0, 12'hFFF, 8'hA5);
    drain();

    // identity-like warp, one pixel per cell, walk across the grid diagonal
    write_reg(REG_COEF_A, {32'h0100_0000, 32'h0});
    write_reg(REG_COEF_B, {32'h0, 32'h0});
    write_reg(REG_COEF_C, {32'h0100_0000, 32'h0});
    write_reg(REG_COEF_D, 64'h0);
    write_reg(REG_COEF_E, 64'(32'h0100_0000));
    write_reg(REG_TAG_CODE, 64'hA5A5_F0F0_0FF0_C3C3);
    write_reg(REG_GRID_SIZE, 64'd6);
    write_reg(REG_BORDER_WIDTH, 64'd1);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 11; i++) queue_pixel(12'(i), 12'(i), 8'h77);
    queue_pixel(12'd3, 12'd5, 8'h11);
    drain();

    // zero denominator on the line x == y
    write_reg(REG_COEF_D, {32'd1, 32'hFFFF_FFFF});
    write_reg(REG_COEF_E, 64'h0);
    queue_pixel(12'd4, 12'd4, 8'h33);
    queue_pixel(12'd4, 12'd5, 8'h33);
    queue_pixel(12'd9, 12'd2, 8'h33);
    drain();

    // extreme coefficients
    write_reg(REG_COEF_A, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(REG_COEF_B, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_COEF_C, {32'h8000_0000, 32'h8000_0000});
    write_reg(REG_COEF_D, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_COEF_E, 64'(32'h8000_0000));
    queue_pixel(12'hFFF, 12'd0, 8'd1);
    queue_pixel(12'd0, 12'hFFF, 8'd2);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_idling(ph);
      if (ph == 9) begin
        // noise: fully random matrix
        write_reg(REG_COEF_A, {$urandom, $urandom});
        write_reg(REG_COEF_B, {$urandom, $urandom});
        write_reg(REG_COEF_C, {$urandom, $urandom});
        write_reg(REG_COEF_D, {$urandom, $urandom});
        write_reg(REG_COEF_E, 64'($urandom));
      end else begin
        load_warp(ph % 2 == 1);
      end
      write_reg(REG_TAG_CODE, {$urandom, $urandom});
      case (ph)
        0: write_reg(REG_GRID_SIZE, 64'd1);
        1: write_reg(REG_GRID_SIZE, 64'd8);
        2: write_reg(REG_GRID_SIZE, 64'd0);
        3: write_reg(REG_GRID_SIZE, 64'd15);
        default: write_reg(REG_GRID_SIZE, 64'($urandom_range(1, 8)));
      endcase
      write_reg(REG_BORDER_WIDTH, 64'(ph % 4));
      queue_random(110);
      drain();
    end

    if (error_count == 0) begin
      $display("tb_projective_tag_overlay_unit passed");
    end else begin
      $display("tb_projective_tag_overlay_unit failed");
    end
    $finish;
  end

endmodule
